### hw/rtl/mra_pkg.sv
// ----------------------------------------------------------------------------
// mra_pkg
// Shared types, constants and the pair hash of the Merkle root accumulator.
// ----------------------------------------------------------------------------
package mra_pkg;

   localparam int HASH_W = 32;
   localparam logic [HASH_W-1:0] COMBINE_PRIME = 32'd16777619;

   typedef struct packed {
      logic [HASH_W-1:0] leaf_hash;
      logic              last_leaf;
   } leaf_type;

   typedef struct packed {
      logic [HASH_W-1:0] root_hash;
      logic              root_matches;
      logic              too_many_leaves;
   } result_type;

   // (left xor right) times the prime, low word kept
   function automatic logic [HASH_W-1:0] pair_hash(input logic [HASH_W-1:0] left,
                                                   input logic [HASH_W-1:0] right);
      logic [HASH_W-1:0] prod;
      prod = (left ^ right) * COMBINE_PRIME;
      return prod;
   endfunction

endpackage

### hw/rtl/mra_req_if.sv
// ----------------------------------------------------------------------------
// mra_req_if
// Leaf channel: one leaf hash and its end-of-stream mark per transfer.
// ----------------------------------------------------------------------------
interface mra_req_if
   import mra_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [HASH_W-1:0] leaf_hash;
   logic              last_leaf;

   modport source (output valid, output leaf_hash, output last_leaf, input ready);
   modport sink   (input valid, input leaf_hash, input last_leaf, output ready);
endinterface

### hw/rtl/mra_rsp_if.sv
// ----------------------------------------------------------------------------
// mra_rsp_if
// Result channel: root hash and status flags, one transfer per stream.
// ----------------------------------------------------------------------------
interface mra_rsp_if
   import mra_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [HASH_W-1:0] root_hash;
   logic              root_matches;
   logic              too_many_leaves;

   modport source (output valid, output root_hash, output root_matches,
                   output too_many_leaves, input ready);
   modport sink   (input valid, input root_hash, input root_matches,
                   input too_many_leaves, output ready);
endinterface

### hw/rtl/mra_csr_if.sv
// ----------------------------------------------------------------------------
// mra_csr_if
// Register write channel carrying the expected root.
// ----------------------------------------------------------------------------
interface mra_csr_if
   import mra_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [HASH_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### hw/rtl/mra_front.sv
// ----------------------------------------------------------------------------
// mra_front
// Front end: takes leaf transfers into a two-entry queue for the engine.
// ----------------------------------------------------------------------------
module mra_front
   import mra_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     in_valid,
   output logic     in_ready,
   input  leaf_type in_item,
   output logic     q_valid,
   output leaf_type q_item,
   input  logic     q_pop
);

   leaf_type   slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;

   assign in_ready = (count_ff != 2'd2);
   assign q_valid  = (count_ff != 2'd0);
   assign q_item   = slot_ff[rd_ptr_ff];
   assign push     = in_valid && in_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ q_pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

### hw/rtl/mra_engine.sv
// ----------------------------------------------------------------------------
// mra_engine
// Back end: merges each leaf up the level store, folds on the last leaf and
// holds the result in an output register.
// ----------------------------------------------------------------------------
module mra_engine
   import mra_pkg::*;
#(
   parameter int MAX_LEVELS = 16
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  leaf_type          q_item,
   output logic              q_pop,
   input  logic [HASH_W-1:0] expected_root,
   output logic              out_valid,
   input  logic              out_ready,
   output result_type        out_result
);

   localparam int LVL_W = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(MAX_LEVELS - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PUSH,
      ST_FOLD,
      ST_DONE
   } state_type;

   state_type             state_ff;
   logic [HASH_W-1:0]     hashes_ff [MAX_LEVELS];
   logic [MAX_LEVELS-1:0] occ_ff;
   logic                  ovf_ff;
   logic [LVL_W-1:0]      lvl_ff;
   logic [HASH_W-1:0]     carry_ff;
   logic [HASH_W-1:0]     acc_ff;
   logic                  have_ff;
   logic                  last_ff;
   logic                  out_valid_ff;
   result_type            out_result_ff;

   logic [HASH_W-1:0]     cur_hash;
   logic [HASH_W-1:0]     prod;

   // one shared combiner for merging and folding
   assign cur_hash = hashes_ff[lvl_ff];
   assign prod     = pair_hash(cur_hash, (state_ff == ST_FOLD) ? acc_ff : carry_ff);

   assign q_pop      = q_valid && (state_ff == ST_IDLE);
   assign out_valid  = out_valid_ff;
   assign out_result = out_result_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         // in ST_DONE the result register is handled by the state itself
         if (out_ready && (state_ff != ST_DONE)) begin
            out_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  carry_ff <= q_item.leaf_hash;
                  last_ff  <= q_item.last_leaf;
                  lvl_ff   <= '0;
                  state_ff <= ST_PUSH;
               end
            end
            ST_PUSH: begin
               if (!occ_ff[lvl_ff] || (lvl_ff == TOP_LVL)) begin
                  if (!occ_ff[lvl_ff]) begin
                     hashes_ff[lvl_ff] <= carry_ff;
                     occ_ff[lvl_ff]    <= 1'b1;
                  end else begin
                     // top level saturates: keep the merged carry there
                     hashes_ff[lvl_ff] <= prod;
                     ovf_ff            <= 1'b1;
                  end
                  lvl_ff   <= '0;
                  have_ff  <= 1'b0;
                  state_ff <= last_ff ? ST_FOLD : ST_IDLE;
               end else begin
                  occ_ff[lvl_ff] <= 1'b0;
                  carry_ff       <= prod;
                  lvl_ff         <= lvl_ff + LVL_W'(1);
               end
            end
            ST_FOLD: begin
               if (occ_ff[lvl_ff]) begin
                  acc_ff  <= have_ff ? prod : cur_hash;
                  have_ff <= 1'b1;
               end
               if (lvl_ff == TOP_LVL) begin
                  state_ff <= ST_DONE;
               end else begin
                  lvl_ff <= lvl_ff + LVL_W'(1);
               end
            end
            ST_DONE: begin
               if (!out_valid_ff || out_ready) begin
                  out_result_ff.root_hash       <= acc_ff;
                  out_result_ff.root_matches    <= (acc_ff == expected_root);
                  out_result_ff.too_many_leaves <= ovf_ff;
                  out_valid_ff                  <= 1'b1;
                  occ_ff                        <= '0;
                  ovf_ff                        <= 1'b0;
                  state_ff                      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

### hw/rtl/merkle_root_accumulator.sv
// ----------------------------------------------------------------------------
// merkle_root_accumulator
// Streams leaf hashes into a per-level store and reports the Merkle root of
// each stream with a match flag against the expected root.
// ----------------------------------------------------------------------------
// Engine: a leaf is taken in ST_IDLE and merged up the store in ST_PUSH, one
// level per cycle, until it lands in a free level or saturates the top one.
// The last leaf then folds every level in ST_FOLD and loads the result in
// ST_DONE once the output register is free; leaves are popped only in ST_IDLE.
// A two-entry queue takes leaves while the engine works or a result waits.
// Synchronous reset clears the queue, level occupancy, overflow flag, result
// valid flag and expected_root; the level hashes are not reset.
module merkle_root_accumulator
   import mra_pkg::*;
#(
   parameter int MAX_LEVELS = 16
) (
   input  logic clock,
   input  logic reset,
   mra_req_if.sink   req_ch,
   mra_rsp_if.source rsp_ch,
   mra_csr_if.sink   csr_ch
);

   logic [HASH_W-1:0] expected_root_ff;
   leaf_type          in_item;
   leaf_type          q_item;
   logic              q_valid;
   logic              q_pop;
   result_type        result;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_root_ff <= '0;
      end else if (csr_ch.valid) begin
         expected_root_ff <= csr_ch.data;
      end
   end

   assign in_item.leaf_hash = req_ch.leaf_hash;
   assign in_item.last_leaf = req_ch.last_leaf;

   mra_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_ch.valid),
      .in_ready (req_ch.ready),
      .in_item  (in_item),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   mra_engine #(
      .MAX_LEVELS (MAX_LEVELS)
   ) u_engine (
      .clock         (clock),
      .reset         (reset),
      .q_valid       (q_valid),
      .q_item        (q_item),
      .q_pop         (q_pop),
      .expected_root (expected_root_ff),
      .out_valid     (rsp_ch.valid),
      .out_ready     (rsp_ch.ready),
      .out_result    (result)
   );

   assign rsp_ch.root_hash       = result.root_hash;
   assign rsp_ch.root_matches    = result.root_matches;
   assign rsp_ch.too_many_leaves = result.too_many_leaves;

   // nothing pending right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_ch.valid && !q_valid))
      else $error("queue or result not empty after reset");

   // engine only pops a queue that holds an item
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("engine popped an empty queue");

   // backpressure to the source only when the queue has an item for the engine
   a_full_has_item: assert property (@(posedge clock) disable iff (reset)
      !req_ch.ready |-> q_valid)
      else $error("leaf channel stalled with empty queue");

endmodule
